@@ rtl/gbgm_pkg.sv @@
// Shared types, constants and helpers for the gap bridge greedy matcher.
package gbgm_pkg;

  localparam int unsigned MAX_ITEMS = 1024;
  localparam int unsigned IW        = $clog2(MAX_ITEMS);  // item index width
  localparam int unsigned CW        = IW + 1;             // counts up to MAX_ITEMS
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned KW        = COORD_W + 2;        // signed key width

  typedef enum logic [1:0] {
    REQ_LOAD_ISLAND = 2'd0,
    REQ_LOAD_BRIDGE = 2'd1,
    REQ_SOLVE       = 2'd2,
    REQ_READ        = 2'd3
  } req_e;

  typedef enum logic {
    CFG_ISLAND_COUNT = 1'b0,
    CFG_BRIDGE_COUNT = 1'b1
  } cfg_idx_e;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  // Heap and order store entry: sort key, item index, carried value.
  typedef struct packed {
    logic signed [KW-1:0] key;
    logic [IW-1:0]        idx;
    logic signed [KW-1:0] aux;
  } heap_ent_t;

  typedef struct packed {
    logic      clear;
    logic      push;
    logic      pop;
    heap_ent_t ent;
  } heap_req_t;

  typedef struct packed {
    logic          done;
    heap_ent_t     top;
    logic [CW-1:0] count;
  } heap_rsp_t;

  function automatic logic ent_less(heap_ent_t a, heap_ent_t b);
    ent_less = (a.key < b.key) || ((a.key == b.key) && (a.idx < b.idx));
  endfunction

endpackage

@@ rtl/gbgm_heap.sv @@
// Binary min-heap held in a synchronous memory, sifted one level per step.
module gbgm_heap (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gbgm_pkg::heap_req_t req_i,
  output gbgm_pkg::heap_rsp_t rsp_o
);
  import gbgm_pkg::*;

  typedef enum logic [7:0] {
    H_IDLE    = 8'b00000001,
    H_PU_CHK  = 8'b00000010,
    H_PU_CMP  = 8'b00000100,
    H_PO_TOP  = 8'b00001000,
    H_PO_LAST = 8'b00010000,
    H_PO_RDL  = 8'b00100000,
    H_PO_RDR  = 8'b01000000,
    H_PO_CMP  = 8'b10000000
  } hstate_e;

  hstate_e       state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] pos_q, pos_d;
  heap_ent_t     ent_q, ent_d, lch_q, lch_d, top_q, top_d;
  logic          done_q, done_d;

  heap_ent_t     mem [MAX_ITEMS];
  heap_ent_t     rd_q;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  heap_ent_t     wr_data;

  logic [IW-1:0] pos_m1, parent;
  logic [CW-1:0] lch_idx, cnt_m1;
  logic [CW:0]   rch_idx;
  logic          have_r;

  assign pos_m1  = pos_q - 1'b1;
  assign parent  = {1'b0, pos_m1[IW-1:1]};
  assign lch_idx = {pos_q, 1'b1};
  assign rch_idx = {1'b0, lch_idx} + 1'b1;
  assign cnt_m1  = cnt_q - 1'b1;
  assign have_r  = rch_idx < {1'b0, cnt_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    ent_d   = ent_q;
    lch_d   = lch_q;
    top_d   = top_q;
    done_d  = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = ent_q;
    case (state_q)
      H_IDLE: begin
        if (req_i.clear) begin
          cnt_d = '0;
        end else if (req_i.push) begin
          ent_d   = req_i.ent;
          pos_d   = cnt_q[IW-1:0];
          cnt_d   = cnt_q + 1'b1;
          state_d = H_PU_CHK;
        end else if (req_i.pop) begin
          state_d = H_PO_TOP;
        end
      end
      H_PU_CHK: begin
        if (pos_q == '0) begin
          wr_en   = 1'b1;
          done_d  = 1'b1;
          state_d = H_IDLE;
        end else begin
          rd_addr = parent;
          state_d = H_PU_CMP;
        end
      end
      H_PU_CMP: begin
        wr_en = 1'b1;
        if (ent_less(ent_q, rd_q)) begin
          // move the parent down into the hole
          wr_data = rd_q;
          pos_d   = parent;
          state_d = H_PU_CHK;
        end else begin
          done_d  = 1'b1;
          state_d = H_IDLE;
        end
      end
      H_PO_TOP: begin
        top_d   = rd_q;
        cnt_d   = cnt_m1;
        rd_addr = cnt_m1[IW-1:0];
        state_d = H_PO_LAST;
      end
      H_PO_LAST: begin
        ent_d   = rd_q;
        pos_d   = '0;
        state_d = H_PO_RDL;
      end
      H_PO_RDL: begin
        if (lch_idx >= cnt_q) begin
          wr_en   = 1'b1;
          done_d  = 1'b1;
          state_d = H_IDLE;
        end else begin
          rd_addr = lch_idx[IW-1:0];
          state_d = H_PO_RDR;
        end
      end
      H_PO_RDR: begin
        lch_d   = rd_q;
        rd_addr = rch_idx[IW-1:0];
        state_d = H_PO_CMP;
      end
      H_PO_CMP: begin
        wr_en = 1'b1;
        if (have_r && ent_less(rd_q, lch_q) && ent_less(rd_q, ent_q)) begin
          wr_data = rd_q;
          pos_d   = rch_idx[IW-1:0];
          state_d = H_PO_RDL;
        end else if (ent_less(lch_q, ent_q)) begin
          wr_data = lch_q;
          pos_d   = lch_idx[IW-1:0];
          state_d = H_PO_RDL;
        end else begin
          done_d  = 1'b1;
          state_d = H_IDLE;
        end
      end
      default: begin
        state_d = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    ent_q <= ent_d;
    lch_q <= lch_d;
    top_q <= top_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.top   = top_q;
  assign rsp_o.count = cnt_q;

endmodule

@@ rtl/gap_bridge_greedy_matcher_unit.sv @@
// Top level: load stores, heap sorting of gaps and bridges, greedy matching.
// Loads write on acceptance; a read goes via S_READ to the result register.
// A solve heap-sorts gaps by low bound and bridges by length, then matches
// through the same heap; a push sifts up through check and compare states
// per heap level, and a pop through left read, right read and compare states.
// Reset clears control, counts and the verdict; data stores are undefined.
module gap_bridge_greedy_matcher_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [gbgm_pkg::CW-1:0]         cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      req_type_i,
  input  logic [gbgm_pkg::IW-1:0]         item_index_i,
  input  logic [gbgm_pkg::COORD_W-1:0]    value_low_i,
  input  logic [gbgm_pkg::COORD_W-1:0]    value_high_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            result_kind_o,
  output logic                            feasible_o,
  output logic [gbgm_pkg::CW-1:0]         assigned_bridge_o
);
  import gbgm_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_READ   = 18'h00002,
    S_GRD_A  = 18'h00004,
    S_GRD_B  = 18'h00008,
    S_GPUSH  = 18'h00010,
    S_GPOP   = 18'h00020,
    S_GPUT   = 18'h00040,
    S_BRD    = 18'h00080,
    S_BPUSH  = 18'h00100,
    S_BPOP   = 18'h00200,
    S_BPUT   = 18'h00400,
    S_MBR_RD = 18'h00800,
    S_MBR    = 18'h01000,
    S_MGAP   = 18'h02000,
    S_MCHK   = 18'h04000,
    S_MTOP   = 18'h08000,
    S_MPUT   = 18'h10000,
    S_HWAIT  = 18'h20000
  } state_e;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  state_e        state_q, state_d, ret_q, ret_d;
  logic [CW-1:0] ic_q, ic_d, bc_q, bc_d;
  logic [CW-1:0] gaps_q, gaps_d, i_q, i_d, p_q, p_d, k_q, k_d, srv_q, srv_d;
  logic          verdict_q, verdict_d;
  logic [IW-1:0] ridx_q, ridx_d;
  logic [COORD_W-1:0] ln_q, ln_d, rn_q, rn_d;
  heap_ent_t     br_q, br_d;
  logic          fin;

  logic          out_valid_q, out_valid_d, kind_q, kind_d, feas_q, feas_d;
  logic [CW-1:0] bridge_q, bridge_d;

  logic          in_acc;
  logic [CW-1:0] i_inc;
  logic [CW-1:0] cfg_sat;

  heap_req_t     hreq;
  heap_rsp_t     hrsp;

  // stores
  logic [COORD_W-1:0] isl_l_mem [MAX_ITEMS];
  logic [COORD_W-1:0] isl_r_mem [MAX_ITEMS];
  logic [COORD_W-1:0] blen_mem  [MAX_ITEMS];
  heap_ent_t          gord_mem  [MAX_ITEMS];
  heap_ent_t          bord_mem  [MAX_ITEMS];
  logic [CW-1:0]      asg_mem   [MAX_ITEMS];

  logic [COORD_W-1:0] isl_l_rd, isl_r_rd, blen_rd;
  heap_ent_t          gord_rd, bord_rd;
  logic [CW-1:0]      asg_rd;
  logic [IW-1:0]      isl_raddr, blen_raddr, gord_raddr, bord_raddr, asg_raddr;
  logic               gord_we, bord_we, asg_we;
  logic [IW-1:0]      ord_waddr, asg_waddr;
  logic [CW-1:0]      asg_wdata;
  logic               isl_we, blen_we;

  logic signed [KW-1:0] gap_lo, gap_hi;

  gbgm_heap u_heap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hreq),
    .rsp_o  (hrsp)
  );

  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign isl_we     = in_acc && (req_e'(req_type_i) == REQ_LOAD_ISLAND);
  assign blen_we    = in_acc && (req_e'(req_type_i) == REQ_LOAD_BRIDGE);
  assign i_inc      = i_q + 1'b1;
  assign cfg_sat    = (cfg_data_i > MAX_CNT) ? MAX_CNT : cfg_data_i;

  assign gap_lo = $signed({2'b00, ln_q}) - $signed({2'b00, isl_r_rd});
  assign gap_hi = $signed({2'b00, rn_q}) - $signed({2'b00, isl_l_rd});

  always_ff @(posedge clk_i) begin
    if (isl_we) begin
      isl_l_mem[item_index_i] <= value_low_i;
      isl_r_mem[item_index_i] <= value_high_i;
    end
    if (blen_we) begin
      blen_mem[item_index_i] <= value_low_i;
    end
    if (gord_we) begin
      gord_mem[ord_waddr] <= hrsp.top;
    end
    if (bord_we) begin
      bord_mem[ord_waddr] <= hrsp.top;
    end
    if (asg_we) begin
      asg_mem[asg_waddr] <= asg_wdata;
    end
    isl_l_rd <= isl_l_mem[isl_raddr];
    isl_r_rd <= isl_r_mem[isl_raddr];
    blen_rd  <= blen_mem[blen_raddr];
    gord_rd  <= gord_mem[gord_raddr];
    bord_rd  <= bord_mem[bord_raddr];
    asg_rd   <= asg_mem[asg_raddr];
  end

  always_comb begin
    ic_d = ic_q;
    bc_d = bc_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ISLAND_COUNT: ic_d = cfg_sat;
        CFG_BRIDGE_COUNT: bc_d = cfg_sat;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    gaps_d      = gaps_q;
    i_d         = i_q;
    p_d         = p_q;
    k_d         = k_q;
    srv_d       = srv_q;
    verdict_d   = verdict_q;
    ridx_d      = ridx_q;
    ln_d        = ln_q;
    rn_d        = rn_q;
    br_d        = br_q;
    fin         = 1'b0;
    hreq        = '0;
    isl_raddr   = i_q[IW-1:0];
    blen_raddr  = i_q[IW-1:0];
    gord_raddr  = p_q[IW-1:0];
    bord_raddr  = k_q[IW-1:0];
    asg_raddr   = item_index_i;
    gord_we     = 1'b0;
    bord_we     = 1'b0;
    asg_we      = 1'b0;
    ord_waddr   = i_q[IW-1:0];
    asg_waddr   = hrsp.top.idx;
    asg_wdata   = {1'b0, br_q.idx} + 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (req_e'(req_type_i))
            REQ_SOLVE: begin
              gaps_d     = (ic_q == '0) ? '0 : ic_q - 1'b1;
              i_d        = '0;
              srv_d      = '0;
              hreq.clear = 1'b1;
              if (bc_q < gaps_d) begin
                verdict_d = 1'b0;
                fin       = 1'b1;
              end else begin
                state_d = S_GRD_A;
              end
            end
            REQ_READ: begin
              ridx_d  = item_index_i;
              state_d = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      S_GRD_A: begin
        if (i_q < gaps_q) begin
          isl_raddr = i_inc[IW-1:0];
          state_d   = S_GRD_B;
        end else begin
          i_d     = '0;
          state_d = S_GPOP;
        end
      end
      S_GRD_B: begin
        ln_d    = isl_l_rd;
        rn_d    = isl_r_rd;
        state_d = S_GPUSH;
      end
      S_GPUSH: begin
        hreq.push    = 1'b1;
        hreq.ent.key = gap_lo;
        hreq.ent.idx = i_q[IW-1:0];
        hreq.ent.aux = gap_hi;
        i_d          = i_inc;
        ret_d        = S_GRD_A;
        state_d      = S_HWAIT;
      end
      S_GPOP: begin
        if (i_q < gaps_q) begin
          hreq.pop = 1'b1;
          ret_d    = S_GPUT;
          state_d  = S_HWAIT;
        end else begin
          i_d     = '0;
          state_d = S_BRD;
        end
      end
      S_GPUT: begin
        gord_we = 1'b1;
        i_d     = i_inc;
        state_d = S_GPOP;
      end
      S_BRD: begin
        if (i_q < bc_q) begin
          state_d = S_BPUSH;
        end else begin
          i_d     = '0;
          state_d = S_BPOP;
        end
      end
      S_BPUSH: begin
        hreq.push    = 1'b1;
        hreq.ent.key = $signed({2'b00, blen_rd});
        hreq.ent.idx = i_q[IW-1:0];
        hreq.ent.aux = '0;
        i_d          = i_inc;
        ret_d        = S_BRD;
        state_d      = S_HWAIT;
      end
      S_BPOP: begin
        if (i_q < bc_q) begin
          hreq.pop = 1'b1;
          ret_d    = S_BPUT;
          state_d  = S_HWAIT;
        end else begin
          k_d     = '0;
          p_d     = '0;
          srv_d   = '0;
          state_d = S_MBR_RD;
        end
      end
      S_BPUT: begin
        bord_we = 1'b1;
        i_d     = i_inc;
        state_d = S_BPOP;
      end
      S_MBR_RD: begin
        if (k_q < bc_q) begin
          state_d = S_MBR;
        end else begin
          verdict_d = (srv_q == gaps_q);
          fin       = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_MBR: begin
        br_d    = bord_rd;
        state_d = S_MGAP;
      end
      S_MGAP: begin
        state_d = (p_q < gaps_q) ? S_MCHK : S_MTOP;
      end
      S_MCHK: begin
        if (br_q.key >= gord_rd.key) begin
          // gap reachable by this bridge: queue it by its upper bound
          hreq.push    = 1'b1;
          hreq.ent.key = gord_rd.aux;
          hreq.ent.idx = gord_rd.idx;
          hreq.ent.aux = '0;
          p_d          = p_q + 1'b1;
          ret_d        = S_MGAP;
          state_d      = S_HWAIT;
        end else begin
          state_d = S_MTOP;
        end
      end
      S_MTOP: begin
        if (hrsp.count == '0) begin
          k_d     = k_q + 1'b1;
          state_d = S_MBR_RD;
        end else begin
          hreq.pop = 1'b1;
          ret_d    = S_MPUT;
          state_d  = S_HWAIT;
        end
      end
      S_MPUT: begin
        if (hrsp.top.key < br_q.key) begin
          verdict_d = 1'b0;
          fin       = 1'b1;
          state_d   = S_IDLE;
        end else begin
          asg_we  = 1'b1;
          srv_d   = srv_q + 1'b1;
          k_d     = k_q + 1'b1;
          state_d = S_MBR_RD;
        end
      end
      S_HWAIT: begin
        if (hrsp.done) begin
          state_d = ret_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result register: hold until taken
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    feas_d      = feas_q;
    bridge_d    = bridge_q;
    if (fin) begin
      out_valid_d = 1'b1;
      kind_d      = KIND_VERDICT;
      feas_d      = verdict_d;
      bridge_d    = '0;
    end else if (state_q == S_READ) begin
      out_valid_d = 1'b1;
      kind_d      = KIND_READ;
      feas_d      = verdict_q;
      bridge_d    = (verdict_q && ({1'b0, ridx_q} < gaps_q)) ? asg_rd : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      ic_q        <= '0;
      bc_q        <= '0;
      gaps_q      <= '0;
      i_q         <= '0;
      p_q         <= '0;
      k_q         <= '0;
      srv_q       <= '0;
      verdict_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      ic_q        <= ic_d;
      bc_q        <= bc_d;
      gaps_q      <= gaps_d;
      i_q         <= i_d;
      p_q         <= p_d;
      k_q         <= k_d;
      srv_q       <= srv_d;
      verdict_q   <= verdict_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q   <= ridx_d;
    ln_q     <= ln_d;
    rn_q     <= rn_d;
    br_q     <= br_d;
    kind_q   <= kind_d;
    feas_q   <= feas_d;
    bridge_q <= bridge_d;
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = kind_q;
  assign feasible_o        = feas_q;
  assign assigned_bridge_o = bridge_q;

`ifndef NO_ASSERTIONS
  a_heap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hrsp.count <= MAX_CNT)
    else $error("heap count exceeds capacity");

  a_served_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (srv_q <= gaps_q) || (state_q == S_GRD_A))
    else $error("more gaps served than exist");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) != S_IDLE) || $past(in_acc))
    else $error("result raised without a solve or read");

  a_wait_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HWAIT) |-> !hreq.push && !hreq.pop)
    else $error("heap request issued while waiting");
`endif

endmodule

@@ tb/sv/gap_bridge_greedy_matcher_unit_checker.sv @@
// Checker for the gap bridge greedy matcher: predicts verdicts and read answers and compares.
module gap_bridge_greedy_matcher_unit_checker
  import gbgm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CW-1:0]       cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [1:0]          req_type_i,
  input  logic [IW-1:0]       item_index_i,
  input  logic [COORD_W-1:0]  value_low_i,
  input  logic [COORD_W-1:0]  value_high_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                result_kind_i,
  input  logic                feasible_i,
  input  logic [CW-1:0]       assigned_bridge_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic          kind;
    logic          feasible;
    logic [CW-1:0] bridge;
  } answer_t;

  answer_t answer_q[$];

  logic [COORD_W-1:0] isl_left[MAX_ITEMS];
  logic [COORD_W-1:0] isl_right[MAX_ITEMS];
  logic [COORD_W-1:0] bridge_len[MAX_ITEMS];
  int                 bridge_of_gap[MAX_ITEMS];
  longint             gap_lo[MAX_ITEMS];
  longint             gap_hi[MAX_ITEMS];
  int                 gap_order[MAX_ITEMS];
  int                 bridge_order[MAX_ITEMS];
  bit                 in_pool[MAX_ITEMS];
  int                 island_cnt, bridge_cnt, solved_gaps;
  logic               verdict;

  assign pending_o = answer_q.size();

  // Greedy matching: ascending bridges, each serves the open gap with the least upper bound.
  function automatic bit match_bridges(int gaps);
    int     i, j, k, t, b, top, pool_cnt, p;
    longint len;
    if (bridge_cnt < gaps) return 0;
    for (i = 0; i < gaps; i++) begin
      gap_lo[i]    = longint'(isl_left[i+1]) - longint'(isl_right[i]);
      gap_hi[i]    = longint'(isl_right[i+1]) - longint'(isl_left[i]);
      gap_order[i] = i;
      in_pool[i]   = 0;
    end
    for (i = 0; i < bridge_cnt; i++) bridge_order[i] = i;
    // stable insertion sorts keep lower index first on ties
    for (i = 1; i < gaps; i++) begin
      t = gap_order[i];
      j = i - 1;
      while (j >= 0 && gap_lo[gap_order[j]] > gap_lo[t]) begin
        gap_order[j+1] = gap_order[j];
        j--;
      end
      gap_order[j+1] = t;
    end
    for (i = 1; i < bridge_cnt; i++) begin
      t = bridge_order[i];
      j = i - 1;
      while (j >= 0 && bridge_len[bridge_order[j]] > bridge_len[t]) begin
        bridge_order[j+1] = bridge_order[j];
        j--;
      end
      bridge_order[j+1] = t;
    end
    p = 0;
    pool_cnt = 0;
    for (k = 0; k < bridge_cnt; k++) begin
      b   = bridge_order[k];
      len = longint'(bridge_len[b]);
      while (p < gaps && len >= gap_lo[gap_order[p]]) begin
        in_pool[gap_order[p]] = 1;
        pool_cnt++;
        p++;
      end
      if (pool_cnt == 0) continue;
      top = -1;
      for (i = 0; i < gaps; i++)
        if (in_pool[i] && (top < 0 || gap_hi[i] < gap_hi[top])) top = i;
      if (gap_hi[top] < len) return 0;
      in_pool[top] = 0;
      pool_cnt--;
      bridge_of_gap[top] = b + 1;
    end
    for (i = 0; i < gaps; i++)
      if (bridge_of_gap[i] == 0) return 0;
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int      gaps, v;
    answer_t exp_a;
    if (!rst_ni) begin
      answer_q.delete();
      fail_count_o = 0;
      island_cnt   = 0;
      bridge_cnt   = 0;
      solved_gaps  = 0;
      verdict      = 0;
      for (int i = 0; i < MAX_ITEMS; i++) bridge_of_gap[i] = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          $error("result with no request outstanding: kind %0d", result_kind_i);
          fail_count_o++;
        end else begin
          exp_a = answer_q.pop_front();
          if (result_kind_i !== exp_a.kind) begin
            $error("result_kind: expected %0d, actual %0d", exp_a.kind, result_kind_i);
            fail_count_o++;
          end
          if (feasible_i !== exp_a.feasible) begin
            $error("feasible: expected %0d, actual %0d", exp_a.feasible, feasible_i);
            fail_count_o++;
          end
          if (assigned_bridge_i !== exp_a.bridge) begin
            $error("assigned_bridge: expected %0d, actual %0d", exp_a.bridge,
                   assigned_bridge_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        v = int'(cfg_data_i);
        if (v > MAX_ITEMS) v = MAX_ITEMS;
        if (cfg_idx_i == CFG_ISLAND_COUNT) island_cnt = v;
        else bridge_cnt = v;
      end
      if (in_valid_i && !in_stall_i) begin
        case (req_e'(req_type_i))
          REQ_LOAD_ISLAND: begin
            isl_left[item_index_i]  = value_low_i;
            isl_right[item_index_i] = value_high_i;
          end
          REQ_LOAD_BRIDGE: bridge_len[item_index_i] = value_low_i;
          REQ_SOLVE: begin
            gaps = (island_cnt > 0) ? island_cnt - 1 : 0;
            for (int i = 0; i < MAX_ITEMS; i++) bridge_of_gap[i] = 0;
            solved_gaps = gaps;
            verdict = match_bridges(gaps);
            if (!verdict)
              for (int i = 0; i < MAX_ITEMS; i++) bridge_of_gap[i] = 0;
            exp_a.kind     = KIND_VERDICT;
            exp_a.feasible = verdict;
            exp_a.bridge   = '0;
            answer_q.push_back(exp_a);
          end
          default: begin
            exp_a.kind     = KIND_READ;
            exp_a.feasible = verdict;
            exp_a.bridge   = (int'(item_index_i) < solved_gaps) ?
                             CW'(bridge_of_gap[item_index_i]) : '0;
            answer_q.push_back(exp_a);
          end
        endcase
      end
    end
  end

endmodule

@@ tb/sv/gap_bridge_greedy_matcher_unit_tb.sv @@
// Testbench top for the gap bridge greedy matcher: clock, reset, stimulus and verdict.
module gap_bridge_greedy_matcher_unit_tb;
  import gbgm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               cfg_we_i = 0;
  logic               cfg_idx_i = 0;
  logic [CW-1:0]      cfg_data_i = '0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic [1:0]         req_type_i = REQ_LOAD_ISLAND;
  logic [IW-1:0]      item_index_i = '0;
  logic [COORD_W-1:0] value_low_i = '0;
  logic [COORD_W-1:0] value_high_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic               result_kind_o;
  logic               feasible_o;
  logic [CW-1:0]      assigned_bridge_o;

  int fail_count, pending;
  int items_sent, n_solves, n_reads, n_phases;
  bit idle_on;
  int stall_pct;
  int hold_tickets, hold_served, hold_cnt, burst_cnt;

  logic [COORD_W-1:0] gen_left[MAX_ITEMS];
  logic [COORD_W-1:0] gen_right[MAX_ITEMS];
  logic [COORD_W-1:0] gen_len[MAX_ITEMS];

  always #6 clk_i = ~clk_i;

  gap_bridge_greedy_matcher_unit DUT (.*);

  gap_bridge_greedy_matcher_unit_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .item_index_i,
    .value_low_i, .value_high_i, .out_valid_i(out_valid_o), .out_stall_i,
    .result_kind_i(result_kind_o), .feasible_i(feasible_o),
    .assigned_bridge_i(assigned_bridge_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver stall: random stalls, occasional bursts, and requested long hold-offs.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 0;
      hold_served <= 0;
      hold_cnt    <= 0;
      burst_cnt   <= 0;
    end else if (hold_served != hold_tickets) begin
      hold_served <= hold_tickets;
      hold_cnt    <= 300;
      out_stall_i <= 1;
    end else if (hold_cnt > 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_stall_i <= (hold_cnt > 1);
    end else if (burst_cnt > 0) begin
      burst_cnt   <= burst_cnt - 1;
      out_stall_i <= (burst_cnt > 1);
    end else if (stall_pct > 0 && $urandom_range(0, 199) == 0) begin
      burst_cnt   <= $urandom_range(10, 40);
      out_stall_i <= 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(req_e t, int idx, logic [COORD_W-1:0] lo, logic [COORD_W-1:0] hi);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i   <= 1;
    req_type_i   <= t;
    item_index_i <= IW'(idx);
    value_low_i  <= lo;
    value_high_i <= hi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (t == REQ_SOLVE) n_solves++;
    if (t == REQ_READ) n_reads++;
  endtask

  // Write a register only once every outstanding answer has drained.
  task automatic cfg_write(cfg_idx_e idx, int data);
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CW'(data);
    @(posedge clk_i);
    cfg_we_i   <= 0;
  endtask

  task automatic run_phase(int cfg_n, int cfg_m, bit formed, bit pressure);
    int               n, m, gaps, scale, i, j, nr;
    longint           pos, lo, hi;
    logic [COORD_W-1:0] tmp;
    n = (cfg_n > MAX_ITEMS) ? MAX_ITEMS : cfg_n;
    m = (cfg_m > MAX_ITEMS) ? MAX_ITEMS : cfg_m;
    gaps = (n > 0) ? n - 1 : 0;
    n_phases++;
    cfg_write(CFG_ISLAND_COUNT, cfg_n);
    cfg_write(CFG_BRIDGE_COUNT, cfg_m);
    // stray loads to arbitrary slots, overwritten below where used
    repeat ($urandom_range(0, 3))
      send(req_e'($urandom_range(0, 1)), $urandom_range(0, MAX_ITEMS - 1), $urandom, $urandom);
    case ($urandom_range(0, 2))
      0: scale = 20;
      1: scale = 1000;
      default: scale = 1 << 20;
    endcase
    if (n > 64) scale = 20;
    pos = (n > 64) ? $urandom_range(0, 1000) : $urandom_range(0, 32'hC000_0000);
    for (i = 0; i < n; i++) begin
      if (formed) begin
        gen_left[i] = pos[31:0];
        pos += $urandom_range(0, scale);
        gen_right[i] = pos[31:0];
        pos += $urandom_range(0, scale);
      end else begin
        gen_left[i]  = $urandom;
        gen_right[i] = $urandom;
      end
    end
    for (i = 0; i < m; i++) begin
      if (formed && i < gaps) begin
        lo = longint'(gen_left[i+1]) - longint'(gen_right[i]);
        hi = longint'(gen_right[i+1]) - longint'(gen_left[i]);
        gen_len[i] = COORD_W'(lo + $urandom_range(0, int'(hi - lo)));
      end else begin
        gen_len[i] = formed ? COORD_W'($urandom_range(0, 3 * scale)) : COORD_W'($urandom);
      end
    end
    if (formed && m > 0 && $urandom_range(0, 9) == 0)
      gen_len[$urandom_range(0, m - 1)] = $urandom_range(0, 4 * scale);
    for (i = m - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = gen_len[i];
      gen_len[i] = gen_len[j];
      gen_len[j] = tmp;
    end
    for (i = 0; i < n; i++) send(REQ_LOAD_ISLAND, i, gen_left[i], gen_right[i]);
    for (i = 0; i < m; i++) send(REQ_LOAD_BRIDGE, i, gen_len[i], $urandom);
    send(REQ_SOLVE, $urandom_range(0, MAX_ITEMS - 1), $urandom, $urandom);
    nr = pressure ? 40 : $urandom_range(1, (gaps + 3 > 40) ? 40 : gaps + 3);
    if (pressure) hold_tickets++;
    repeat (nr) begin
      if ($urandom_range(0, 4) != 0) send(REQ_READ, $urandom_range(0, gaps), $urandom, $urandom);
      else send(REQ_READ, $urandom_range(0, MAX_ITEMS - 1), $urandom, $urandom);
    end
  endtask

  initial begin
    int n, m;
    bit pressed;
    idle_on   = 1;
    stall_pct = 20;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // reads before any solve, then solves with no gaps
    send(REQ_READ, 0, '0, '0);
    send(REQ_READ, MAX_ITEMS - 1, '1, '1);
    send(REQ_SOLVE, 0, '0, '0);
    cfg_write(CFG_ISLAND_COUNT, 1);
    send(REQ_LOAD_ISLAND, 0, '1, '0);
    send(REQ_SOLVE, 0, '0, '0);
    send(REQ_READ, 0, '0, '0);
    // extreme coordinates: one gap spanning the full range, bridged by the longest length
    cfg_write(CFG_ISLAND_COUNT, 2);
    cfg_write(CFG_BRIDGE_COUNT, 1);
    send(REQ_LOAD_ISLAND, 0, '0, '0);
    send(REQ_LOAD_ISLAND, 1, '1, '1);
    send(REQ_LOAD_BRIDGE, 0, '1, '0);
    send(REQ_SOLVE, 0, '0, '0);
    send(REQ_READ, 0, '0, '0);
    send(REQ_READ, 1, '0, '0);
    send(REQ_READ, MAX_ITEMS - 1, '0, '0);
    // too few bridges
    run_phase(5, 2, 1, 0);

    pressed = 0;
    while (items_sent < 600) begin
      idle_on   = ($urandom_range(0, 3) != 0);
      stall_pct = idle_on ? $urandom_range(5, 40) : 0;
      n = $urandom_range(0, 12);
      m = n + $urandom_range(0, 3) - ($urandom_range(0, 5) == 0 ? 2 : 0);
      if (m < 0) m = 0;
      run_phase(n, m, $urandom_range(0, 9) < 7, !pressed);
      pressed = 1;
    end
    // larger run that reaches several heap levels
    idle_on   = 0;
    stall_pct = 10;
    run_phase(160, 180, 1, 0);

    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d phases, %0d requests: %0d solves and %0d assignment reads.",
             n_phases, items_sent, n_solves, n_reads);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d answers outstanding", pending);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
